>>> hdl/ntcn_pkg.sv
// Shared types and symbol codes for the number to Chinese numeral unit.
// Used by the channel interfaces and by the top level; depends on nothing.
`timescale 1ns / 1ps

package ntcn_pkg;

    typedef logic [31:0] value_t;
    typedef logic [3:0]  symbol_t;

    // Symbol codes on the output channel.
    localparam symbol_t SYM_ZERO     = 4'd0;
    localparam symbol_t SYM_TEN      = 4'd10;
    localparam symbol_t SYM_HUNDRED  = 4'd11;
    localparam symbol_t SYM_THOUSAND = 4'd12;
    localparam symbol_t SYM_WAN      = 4'd13;
    localparam symbol_t SYM_YI       = 4'd14;

    // Decimal conversion geometry.
    localparam int DEC_DIGITS   = 10;
    localparam int BCD_WIDTH    = 4 * DEC_DIGITS;
    localparam int DD_STAGES    = 4;
    localparam int DD_BITS      = 32 / DD_STAGES;

    // Fixed slot layout: three sections of thirteen slots, the last section
    // having no section unit.
    localparam int SECTIONS     = 3;
    localparam int SEC_SLOTS    = 13;
    localparam int SLOT_COUNT   = SECTIONS * SEC_SLOTS - 1;

    typedef logic [SLOT_COUNT-1:0] slot_mask_t;
    typedef symbol_t [SLOT_COUNT-1:0] slot_syms_t;

endpackage

>>> hdl/ntcn_value_if.sv
// Input channel carrying one unsigned 32-bit value per item.
// Depends on ntcn_pkg for the payload type.
`timescale 1ns / 1ps

interface ntcn_value_if;
    logic            valid;
    logic            ready;
    ntcn_pkg::value_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> hdl/ntcn_symbol_if.sv
// Output channel carrying one numeral symbol per item, with an end marker.
// Depends on ntcn_pkg for the payload type.
`timescale 1ns / 1ps

interface ntcn_symbol_if;
    logic              valid;
    logic              ready;
    ntcn_pkg::symbol_t symbol;
    logic              last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

>>> hdl/number_to_chinese_numeral_unit.sv
// Top level of the number to Chinese numeral unit.
// Depends on ntcn_pkg, ntcn_value_if and ntcn_symbol_if.
`timescale 1ns / 1ps

// Usage
// The number channel takes one unsigned 32-bit value per item. For each value
// the numeral channel gives its Chinese numeral as a run of symbol items, most
// significant first, with last set on the final symbol of the numeral.
// Codes 0 to 9 are digits, 10 ten, 11 hundred, 12 thousand, 13 wan, 14 yi.
// The path from an accepted value to its first symbol runs through one input
// register, four binary to decimal stages of eight bits each, a slot building
// stage, the serialiser and the output register. A value that yields n
// symbols (1 to 19) holds the serialiser until its last symbol is out, one
// symbol per cycle while the numeral channel does not stall; the serialiser
// sets the sustained rate, and the symbols of consecutive values follow each
// other with no gap.
// Every stage carries its own valid bit, so a new value is taken in every
// cycle while the pipeline has room, even when the receiver is stalling.
// A stall on the numeral channel holds the output register and, once the
// stages behind it fill up, drops ready on the number channel; nothing is
// lost or repeated.
// Reset clears all valid bits; the unit holds no state between values.

module number_to_chinese_numeral_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    ntcn_value_if.sink           number,
    ntcn_symbol_if.source        numeral
);
    import ntcn_pkg::*;

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    value_t                in_value_reg;

    logic [DD_STAGES-1:0]  dd_valid_reg;
    logic [BCD_WIDTH-1:0]  dd_bcd_reg [DD_STAGES];
    value_t                dd_bin_reg [DD_STAGES];

    logic                  slot_valid_reg;
    slot_mask_t            slot_mask_reg;
    slot_syms_t            slot_syms_reg;

    logic                  ser_valid_reg;
    slot_mask_t            ser_mask_reg;
    slot_syms_t            ser_syms_reg;

    logic                  out_valid_reg;
    symbol_t               out_symbol_reg;
    logic                  out_last_reg;

    // ------------------------------------------------------------------
    // Flow control. Each stage moves on when the stage after it is empty
    // or moving on itself in the same cycle.
    // ------------------------------------------------------------------
    logic                  out_load;
    logic                  emit;
    logic                  emit_last;
    logic                  ser_free;
    logic                  slot_ready;
    logic [DD_STAGES-1:0]  dd_ready;
    logic                  in_ready;

    slot_mask_t            low_bit;
    slot_mask_t            rest_mask;
    symbol_t               pick_symbol;

    assign out_load   = !out_valid_reg || numeral.ready;
    assign emit       = ser_valid_reg && out_load;
    assign emit_last  = (rest_mask == '0);
    assign ser_free   = !ser_valid_reg || (emit && emit_last);
    assign slot_ready = !slot_valid_reg || ser_free;

    always_comb
    begin
        dd_ready[DD_STAGES-1] = !dd_valid_reg[DD_STAGES-1] || slot_ready;
        for (int s = DD_STAGES - 2; s >= 0; s--)
        begin
            dd_ready[s] = !dd_valid_reg[s] || dd_ready[s+1];
        end
    end

    assign in_ready     = !in_valid_reg || dd_ready[0];
    assign number.ready = in_ready;

    // ------------------------------------------------------------------
    // Binary to decimal conversion by shift and add-three, eight bits per
    // stage. The remaining binary bits shift out of the top of bin.
    // ------------------------------------------------------------------
    logic [BCD_WIDTH-1:0]  dd_bcd_next [DD_STAGES];
    value_t                dd_bin_next [DD_STAGES];

    always_comb
    begin
        logic [BCD_WIDTH-1:0] bcd;
        value_t               bin;
        for (int s = 0; s < DD_STAGES; s++)
        begin
            if (s == 0)
            begin
                bcd = '0;
                bin = in_value_reg;
            end
            else
            begin
                bcd = dd_bcd_reg[s-1];
                bin = dd_bin_reg[s-1];
            end
            for (int b = 0; b < DD_BITS; b++)
            begin
                for (int d = 0; d < DEC_DIGITS; d++)
                begin
                    if (bcd[4*d +: 4] >= 4'd5)
                    begin
                        bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
                    end
                end
                bcd = {bcd[BCD_WIDTH-2:0], bin[31]};
                bin = {bin[30:0], 1'b0};
            end
            dd_bcd_next[s] = bcd;
            dd_bin_next[s] = bin;
        end
    end

    // ------------------------------------------------------------------
    // Slot building. Each section has a fixed run of slots: a leading zero,
    // then for each of its four digits a zero, the digit and, but for the units
    // digit, its unit, and finally the section unit. Only the slots that the
    // numeral needs are marked; the serialiser skips the rest.
    // ------------------------------------------------------------------
    slot_mask_t            slot_mask_next;
    slot_syms_t            slot_syms_next;

    always_comb
    begin
        logic [BCD_WIDTH-1:0] bcd;
        logic [3:0]           dig [SECTIONS][4];
        logic [SECTIONS-1:0]  sec_nz;
        logic                 above;
        logic                 started;
        logic                 pending;
        int                   base;
        int                   pos;

        bcd            = dd_bcd_reg[DD_STAGES-1];
        slot_mask_next = '0;
        slot_syms_next = '0;

        // Section k, digit i counts from the thousands place down.
        for (int k = 0; k < SECTIONS; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pos = (SECTIONS - 1 - k) * 4 + (3 - i);
                if (pos < DEC_DIGITS)
                begin
                    dig[k][i] = bcd[4*pos +: 4];
                end
                else
                begin
                    dig[k][i] = 4'd0;
                end
            end
            sec_nz[k] = (dig[k][0] != 4'd0) || (dig[k][1] != 4'd0) ||
                        (dig[k][2] != 4'd0) || (dig[k][3] != 4'd0);
        end

        for (int k = 0; k < SECTIONS; k++)
        begin
            base    = k * SEC_SLOTS;
            above   = (k == 1) ? sec_nz[0] :
                      (k == 2) ? (sec_nz[0] || sec_nz[1]) : 1'b0;
            started = 1'b0;
            pending = 1'b0;

            // A section below one thousand after a nonzero higher part.
            slot_syms_next[base] = SYM_ZERO;
            slot_mask_next[base] = sec_nz[k] && (dig[k][0] == 4'd0) && above;

            for (int i = 0; i < 4; i++)
            begin
                slot_syms_next[base + 1 + 3*i] = SYM_ZERO;
                slot_syms_next[base + 2 + 3*i] = dig[k][i];
                if (dig[k][i] == 4'd0)
                begin
                    if (started)
                    begin
                        pending = 1'b1;
                    end
                end
                else
                begin
                    slot_mask_next[base + 1 + 3*i] = pending;
                    slot_mask_next[base + 2 + 3*i] = 1'b1;
                    pending = 1'b0;
                    started = 1'b1;
                end
                if (i < 3)
                begin
                    slot_syms_next[base + 3 + 3*i] =
                        (i == 0) ? SYM_THOUSAND : (i == 1) ? SYM_HUNDRED : SYM_TEN;
                    slot_mask_next[base + 3 + 3*i] = (dig[k][i] != 4'd0);
                end
            end

            if (k < SECTIONS - 1)
            begin
                slot_syms_next[base + SEC_SLOTS - 1] = (k == 0) ? SYM_YI : SYM_WAN;
                slot_mask_next[base + SEC_SLOTS - 1] = sec_nz[k];
            end
        end

        // A zero value shows its units digit, which holds zero.
        if (sec_nz == '0)
        begin
            slot_mask_next[(SECTIONS - 1) * SEC_SLOTS + 11] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Serialiser: picks the lowest marked slot each cycle.
    // ------------------------------------------------------------------
    assign low_bit   = ser_mask_reg & (~ser_mask_reg + slot_mask_t'(1));
    assign rest_mask = ser_mask_reg & ~low_bit;

    always_comb
    begin
        pick_symbol = '0;
        for (int j = 0; j < SLOT_COUNT; j++)
        begin
            pick_symbol = pick_symbol | (ser_syms_reg[j] & {4{low_bit[j]}});
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            dd_valid_reg   <= '0;
            slot_valid_reg <= 1'b0;
            ser_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= number.valid;
            end
            if (dd_ready[0])
            begin
                dd_valid_reg[0] <= in_valid_reg;
            end
            for (int s = 1; s < DD_STAGES; s++)
            begin
                if (dd_ready[s])
                begin
                    dd_valid_reg[s] <= dd_valid_reg[s-1];
                end
            end
            if (slot_ready)
            begin
                slot_valid_reg <= dd_valid_reg[DD_STAGES-1];
            end
            if (ser_free)
            begin
                ser_valid_reg <= slot_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            in_value_reg <= number.value;
        end
        for (int s = 0; s < DD_STAGES; s++)
        begin
            if (dd_ready[s])
            begin
                dd_bcd_reg[s] <= dd_bcd_next[s];
                dd_bin_reg[s] <= dd_bin_next[s];
            end
        end
        if (slot_ready)
        begin
            slot_mask_reg <= slot_mask_next;
            slot_syms_reg <= slot_syms_next;
        end
        if (ser_free)
        begin
            ser_mask_reg <= slot_mask_reg;
            ser_syms_reg <= slot_syms_reg;
        end
        else if (emit)
        begin
            ser_mask_reg <= rest_mask;
        end
        if (emit)
        begin
            out_symbol_reg <= pick_symbol;
            out_last_reg   <= emit_last;
        end
    end

    assign numeral.valid  = out_valid_reg;
    assign numeral.symbol = out_symbol_reg;
    assign numeral.last   = out_last_reg;

endmodule
